// File: rtl/core/bmp_pkg.sv
// Shared package for the bone matrix palette builder.
// Holds the sequencer states, the palette row type, the compose control struct,
// the register map and the saturation helper. It has no dependencies.
package bmp_pkg;

    localparam int MAX_BONES_DEF        = 128;
    localparam int QUAT_FRAC_BITS_DEF   = 15;
    localparam int OFFSET_FRAC_BITS_DEF = 6;

    localparam int ROWS        = 3;
    localparam int IDX_W       = 7;
    localparam int COMP_W      = 17;   // quaternion component, wide enough for 1.0
    localparam int RAW_W       = 16;
    localparam int ENTRY_W     = 32;
    localparam int ADDR_CALC_W = 12;
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 136;

    localparam logic [1:0] ROW_LAST = 2'd2;

    // Register map, by word index.
    localparam logic REG_ANIM_BONE_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_ROT,
        S_READ,
        S_MUL,
        S_SUM
    } state_t;

    // One 3x4 matrix row: three rotation entries and the translation.
    typedef struct packed {
        logic signed [ENTRY_W-1:0] ct;
        logic signed [ENTRY_W-1:0] c2;
        logic signed [ENTRY_W-1:0] c1;
        logic signed [ENTRY_W-1:0] c0;
    } row_t;

    typedef struct packed {
        logic             rd_en;
        logic             mul_en;
        logic             wr_en;
        logic             use_parent;
        logic [1:0]       row;
        logic [IDX_W-1:0] parent;
        logic [IDX_W-1:0] bone;
    } cmp_ctrl_t;

    function automatic logic signed [ENTRY_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7fffffff;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[ENTRY_W-1:0];
    endfunction

endpackage

// File: rtl/core/bmp_quat_rot.sv
// Quaternion to 3x3 rotation in two registered steps: products, then sums and rounding.
// Depends on bmp_pkg.
module bmp_quat_rot #(
    parameter int QUAT_FRAC_BITS = bmp_pkg::QUAT_FRAC_BITS_DEF,
    parameter int ROT_W          = 38 - (2 * QUAT_FRAC_BITS - 16)
) (
    input  logic                              clk,
    input  logic                              prod_en,
    input  logic                              rot_en,
    input  logic signed [bmp_pkg::COMP_W-1:0] x,
    input  logic signed [bmp_pkg::COMP_W-1:0] y,
    input  logic signed [bmp_pkg::COMP_W-1:0] z,
    input  logic signed [bmp_pkg::COMP_W-1:0] w,
    output logic signed [ROT_W-1:0]           rot [3][3]
);

    localparam int PW = 2 * bmp_pkg::COMP_W;
    localparam int RW = 38;
    localparam int RS = 2 * QUAT_FRAC_BITS - 16;
    localparam logic signed [RW-1:0] ONE  = RW'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
    localparam logic signed [RW-1:0] HALF = RW'((64'sd1 <<< RS) >>> 1);

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [RW-1:0] pre [3][3];
    logic signed [ROT_W-1:0] rot_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            xx_reg <= x * x;
            yy_reg <= y * y;
            zz_reg <= z * z;
            xy_reg <= x * y;
            xz_reg <= x * z;
            yz_reg <= y * z;
            wx_reg <= w * x;
            wy_reg <= w * y;
            wz_reg <= w * z;
        end
    end

    always_comb
    begin
        pre[0][0] = ONE - ((RW'(yy_reg) + RW'(zz_reg)) <<< 1);
        pre[0][1] = (RW'(xy_reg) - RW'(wz_reg)) <<< 1;
        pre[0][2] = (RW'(xz_reg) + RW'(wy_reg)) <<< 1;
        pre[1][0] = (RW'(xy_reg) + RW'(wz_reg)) <<< 1;
        pre[1][1] = ONE - ((RW'(xx_reg) + RW'(zz_reg)) <<< 1);
        pre[1][2] = (RW'(yz_reg) - RW'(wx_reg)) <<< 1;
        pre[2][0] = (RW'(xz_reg) - RW'(wy_reg)) <<< 1;
        pre[2][1] = (RW'(yz_reg) + RW'(wx_reg)) <<< 1;
        pre[2][2] = ONE - ((RW'(xx_reg) + RW'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (rot_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rot_reg[r][c] <= ROT_W'((pre[r][c] + HALF) >>> RS);
                end
            end
        end
    end

    assign rot = rot_reg;

endmodule

// File: rtl/core/bmp_compose.sv
// Palette memory and the per-row compose datapath (parent row times local matrix).
// Depends on bmp_pkg.
module bmp_compose #(
    parameter int MAX_BONES        = bmp_pkg::MAX_BONES_DEF,
    parameter int OFFSET_FRAC_BITS = bmp_pkg::OFFSET_FRAC_BITS_DEF,
    parameter int ROT_W            = 24
) (
    input  logic                             clk,
    input  bmp_pkg::cmp_ctrl_t               ctrl,
    input  logic signed [ROT_W-1:0]          rot [3][3],
    input  logic signed [bmp_pkg::RAW_W-1:0] raw [3],
    output bmp_pkg::row_t                    row_out
);

    localparam int DEPTH = MAX_BONES * bmp_pkg::ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = bmp_pkg::ENTRY_W;
    localparam int PRW   = EW + ROT_W;
    localparam int ACC_W = PRW + 2;
    localparam int PTW   = EW + bmp_pkg::RAW_W;
    localparam int TW    = PTW + 2 + 16;
    localparam logic signed [ACC_W-1:0] RHALF = ACC_W'(64'sd1 <<< 15);
    localparam logic signed [TW-1:0]    THALF = TW'((64'sd1 <<< OFFSET_FRAC_BITS) >>> 1);

    bmp_pkg::row_t mem [DEPTH];
    bmp_pkg::row_t rd_q;

    logic [bmp_pkg::ADDR_CALC_W-1:0] rd_calc, wr_calc;
    logic [AW-1:0] rd_addr, wr_addr;

    logic signed [PRW-1:0] pr_reg [3][3];
    logic signed [PTW-1:0] pt_reg [3];
    logic signed [EW-1:0]  pm3_reg;
    logic signed [EW-1:0]  pm [3];

    logic signed [ACC_W-1:0] acc [3];
    logic signed [TW-1:0]    tacc;
    bmp_pkg::row_t comp_row, root_row;

    always_comb
    begin
        rd_calc = ((bmp_pkg::ADDR_CALC_W'(ctrl.parent)) << 1) + bmp_pkg::ADDR_CALC_W'(ctrl.parent)
                + bmp_pkg::ADDR_CALC_W'(ctrl.row);
        wr_calc = ((bmp_pkg::ADDR_CALC_W'(ctrl.bone)) << 1) + bmp_pkg::ADDR_CALC_W'(ctrl.bone)
                + bmp_pkg::ADDR_CALC_W'(ctrl.row);
        rd_addr = AW'(rd_calc);
        wr_addr = AW'(wr_calc);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= row_out;
        end
        if (ctrl.rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    assign pm[0] = rd_q.c0;
    assign pm[1] = rd_q.c1;
    assign pm[2] = rd_q.c2;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pr_reg[c][k] <= pm[k] * rot[k][c];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                pt_reg[k] <= pm[k] * raw[k];
            end
            pm3_reg <= rd_q.ct;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = ACC_W'(pr_reg[c][0]) + ACC_W'(pr_reg[c][1]) + ACC_W'(pr_reg[c][2]);
        end
        tacc = TW'(pt_reg[0]) + TW'(pt_reg[1]) + TW'(pt_reg[2])
             + (TW'(pm3_reg) <<< OFFSET_FRAC_BITS);

        comp_row.c0 = bmp_pkg::sat32(64'((acc[0] + RHALF) >>> 16));
        comp_row.c1 = bmp_pkg::sat32(64'((acc[1] + RHALF) >>> 16));
        comp_row.c2 = bmp_pkg::sat32(64'((acc[2] + RHALF) >>> 16));
        comp_row.ct = bmp_pkg::sat32(64'((tacc + THALF) >>> OFFSET_FRAC_BITS));

        root_row.c0 = bmp_pkg::sat32(64'(rot[ctrl.row][0]));
        root_row.c1 = bmp_pkg::sat32(64'(rot[ctrl.row][1]));
        root_row.c2 = bmp_pkg::sat32(64'(rot[ctrl.row][2]));
        root_row.ct = bmp_pkg::sat32(64'(raw[ctrl.row]) <<< (16 - OFFSET_FRAC_BITS));

        row_out = ctrl.use_parent ? comp_row : root_row;
    end

endmodule

// File: rtl/core/bone_matrix_palette_builder.sv
// Top level of the bone matrix palette builder: stream ports, APB register,
// sequencer and output register. Depends on bmp_pkg, bmp_quat_rot and bmp_compose.
//
//  Channel   Dir  Handshake                Carries
//  s_*       in   s_tvalid / s_tready      one bone: index, parent, quaternion, offset
//  m_*       out  m_tvalid / m_tready      one matrix row: bone, row, four entries
//  APB       in   psel, penable, pready    anim_bone_count at word 0
//
// A bone passes through the idle state that takes the item, the products and rotation
// steps that build the rotation, then, for each of the three rows, the palette read,
// the parent products and the sum, round and saturate step. The rows run one after
// another through the palette memory, and a new bone is taken only after the last row
// of the previous one is loaded. A row waits in the sum step while the output register
// still holds an untaken row. Reset clears the sequencer, the register and the output
// valid flag; the palette needs no clearing if the user writes a parent before any
// child reads it, which the block itself does not enforce.
module bone_matrix_palette_builder #(
    parameter int MAX_BONES        = bmp_pkg::MAX_BONES_DEF,
    parameter int QUAT_FRAC_BITS   = bmp_pkg::QUAT_FRAC_BITS_DEF,
    parameter int OFFSET_FRAC_BITS = bmp_pkg::OFFSET_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bone_index[6:0], parent_index[14:7], quat_x[30:15], quat_y[46:31],
    // quat_z[62:47], quat_w[78:63], offset_x[94:79], offset_y[110:95],
    // offset_z[126:111], zero fill [127]
    input  logic [bmp_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_bone[6:0], col_zero[38:7], col_one[70:39], col_two[102:71],
    // col_trans[134:103], zero fill [135]
    output logic [bmp_pkg::OUT_DATA_W-1:0]    m_tdata,
    // row_index[1:0]
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int ROT_W = 38 - (2 * QUAT_FRAC_BITS - 16);
    localparam logic signed [bmp_pkg::COMP_W-1:0] W_ONE =
        bmp_pkg::COMP_W'(64'sd1 <<< QUAT_FRAC_BITS);

    // Configuration register.
    logic [7:0] bone_limit_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bone_limit_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == bmp_pkg::REG_ANIM_BONE_COUNT)
        begin
            bone_limit_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == bmp_pkg::REG_ANIM_BONE_COUNT) ? {24'd0, bone_limit_reg} : '0;

    // Input fields.
    logic [6:0]         in_bone;
    logic signed [7:0]  in_parent;
    logic               in_anim;
    logic               in_ok;

    assign in_bone   = s_tdata[6:0];
    assign in_parent = s_tdata[14:7];
    assign in_anim   = {1'b0, in_bone} < bone_limit_reg;
    assign in_ok     = int'(in_bone) < MAX_BONES;

    // Captured bone.
    logic [6:0] bone_reg;
    logic [6:0] parent_reg;
    logic       use_parent_reg;
    logic signed [bmp_pkg::COMP_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [bmp_pkg::RAW_W-1:0]  raw_reg [3];

    // Sequencer.
    bmp_pkg::state_t state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic       accept;
    logic       out_free;
    logic       load_out;
    bmp_pkg::cmp_ctrl_t ctrl;

    // Output register.
    logic          out_valid_reg;
    logic [6:0]    out_bone_reg;
    logic [1:0]    out_row_reg;
    bmp_pkg::row_t out_data_reg;
    bmp_pkg::row_t row_out;

    logic signed [ROT_W-1:0] rot [3][3];

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        ctrl       = '0;
        ctrl.use_parent = use_parent_reg;
        ctrl.row        = row_reg;
        ctrl.parent     = parent_reg;
        ctrl.bone       = bone_reg;
        unique case (state_reg)
            bmp_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                row_next = '0;
                if (s_tvalid && in_ok)
                begin
                    state_next = bmp_pkg::S_PROD;
                end
            end
            bmp_pkg::S_PROD:
            begin
                state_next = bmp_pkg::S_ROT;
            end
            bmp_pkg::S_ROT:
            begin
                state_next = bmp_pkg::S_READ;
            end
            bmp_pkg::S_READ:
            begin
                ctrl.rd_en = use_parent_reg;
                state_next = bmp_pkg::S_MUL;
            end
            bmp_pkg::S_MUL:
            begin
                ctrl.mul_en = use_parent_reg;
                state_next  = bmp_pkg::S_SUM;
            end
            bmp_pkg::S_SUM:
            begin
                if (out_free)
                begin
                    ctrl.wr_en = 1'b1;
                    load_out   = 1'b1;
                    if (row_reg == bmp_pkg::ROW_LAST)
                    begin
                        state_next = bmp_pkg::S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = bmp_pkg::S_READ;
                    end
                end
            end
            default:
            begin
                state_next = bmp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmp_pkg::S_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    // Capture; bones past the animated count take the identity pose.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bone_reg       <= in_bone;
            parent_reg     <= in_parent[6:0];
            use_parent_reg <= !in_parent[7] && (in_parent[6:0] < in_bone);
            if (in_anim)
            begin
                qx_reg     <= bmp_pkg::COMP_W'($signed(s_tdata[30:15]));
                qy_reg     <= bmp_pkg::COMP_W'($signed(s_tdata[46:31]));
                qz_reg     <= bmp_pkg::COMP_W'($signed(s_tdata[62:47]));
                qw_reg     <= bmp_pkg::COMP_W'($signed(s_tdata[78:63]));
                raw_reg[0] <= s_tdata[94:79];
                raw_reg[1] <= s_tdata[110:95];
                raw_reg[2] <= s_tdata[126:111];
            end
            else
            begin
                qx_reg     <= '0;
                qy_reg     <= '0;
                qz_reg     <= '0;
                qw_reg     <= W_ONE;
                raw_reg[0] <= '0;
                raw_reg[1] <= '0;
                raw_reg[2] <= '0;
            end
        end
    end

    bmp_quat_rot #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS),
        .ROT_W         (ROT_W)
    ) u_quat_rot (
        .clk    (clk),
        .prod_en(state_reg == bmp_pkg::S_PROD),
        .rot_en (state_reg == bmp_pkg::S_ROT),
        .x      (qx_reg),
        .y      (qy_reg),
        .z      (qz_reg),
        .w      (qw_reg),
        .rot    (rot)
    );

    bmp_compose #(
        .MAX_BONES       (MAX_BONES),
        .OFFSET_FRAC_BITS(OFFSET_FRAC_BITS),
        .ROT_W           (ROT_W)
    ) u_compose (
        .clk    (clk),
        .ctrl   (ctrl),
        .rot    (rot),
        .raw    (raw_reg),
        .row_out(row_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_bone_reg <= bone_reg;
            out_row_reg  <= row_reg;
            out_data_reg <= row_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.ct, out_data_reg.c2, out_data_reg.c1,
                       out_data_reg.c0, out_bone_reg};
    assign m_tuser  = out_row_reg;
    assign m_tlast  = (out_row_reg == bmp_pkg::ROW_LAST);

    // A bone that is taken locks out the next one until its rows are done.
    a_accept_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ok) |=> !s_tready)
        else $error("input taken again while a bone is in work");

    // The sum step always loads the output register when it is free.
    a_sum_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmp_pkg::S_SUM && out_free) |=> m_tvalid)
        else $error("row finished but no output presented");

    // Rows leave in order: after a first or middle row the next loaded row follows it.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && row_reg != bmp_pkg::ROW_LAST) |=> (row_reg == $past(row_reg) + 2'd1))
        else $error("row counter skipped");

    // The ready side is open only in the idle state.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == bmp_pkg::S_IDLE && !load_out))
        else $error("input ready outside idle");

endmodule

// File: tb/bone_matrix_palette_builder_tb.sv
// Self-checking testbench for the bone matrix palette builder.
// Drives bones on the input stream and the animated-bone count over APB, predicts every
// matrix row in a scoreboard class and checks the output stream. Depends on bmp_pkg and the RTL.
module bone_matrix_palette_builder_tb;

    // One expected or observed matrix row.
    typedef struct {
        logic [6:0]         bone;
        logic [1:0]         row;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] ct;
        logic               last;
    } mat_row_t;

    // The scoreboard keeps its own palette and register copy, builds the three rows
    // of each accepted bone and compares observed rows in order.
    class palette_scoreboard;
        longint   palette [128][3][4];
        int       animated_bones;
        mat_row_t pending_rows [$];
        int       mismatches;

        function new();
            animated_bones = 0;
            mismatches = 0;
        endfunction

        // Round half toward plus infinity, then floor shift.
        function longint round_shift(longint v, int s);
            if (s == 0)
            begin
                return v;
            end
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void note_bone(logic [127:0] d);
            int       bone;
            int       parent;
            longint   x, y, z, w, one;
            longint   ofs [3];
            longint   rot [3][3];
            longint   m [3][4];
            longint   acc;
            mat_row_t r;
            bone   = int'(d[6:0]);
            parent = int'($signed(d[14:7]));
            if (bone < animated_bones)
            begin
                x = longint'($signed(d[30:15]));
                y = longint'($signed(d[46:31]));
                z = longint'($signed(d[62:47]));
                w = longint'($signed(d[78:63]));
                ofs[0] = longint'($signed(d[94:79]));
                ofs[1] = longint'($signed(d[110:95]));
                ofs[2] = longint'($signed(d[126:111]));
            end
            else
            begin
                // Identity pose for bones that are not animated.
                x = 0;
                y = 0;
                z = 0;
                w = longint'(1) << 15;
                ofs[0] = 0;
                ofs[1] = 0;
                ofs[2] = 0;
            end
            one = longint'(1) << 30;
            rot[0][0] = round_shift(one - 2 * (y * y + z * z), 14);
            rot[0][1] = round_shift(2 * (x * y - w * z), 14);
            rot[0][2] = round_shift(2 * (x * z + w * y), 14);
            rot[1][0] = round_shift(2 * (x * y + w * z), 14);
            rot[1][1] = round_shift(one - 2 * (x * x + z * z), 14);
            rot[1][2] = round_shift(2 * (y * z - w * x), 14);
            rot[2][0] = round_shift(2 * (x * z - w * y), 14);
            rot[2][1] = round_shift(2 * (y * z + w * x), 14);
            rot[2][2] = round_shift(one - 2 * (x * x + y * y), 14);
            if (parent >= 0 && parent < bone)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        acc = palette[parent][i][0] * rot[0][c]
                            + palette[parent][i][1] * rot[1][c]
                            + palette[parent][i][2] * rot[2][c];
                        m[i][c] = clamp32(round_shift(acc, 16));
                    end
                    acc = palette[parent][i][0] * ofs[0] + palette[parent][i][1] * ofs[1]
                        + palette[parent][i][2] * ofs[2] + (palette[parent][i][3] << 6);
                    m[i][3] = clamp32(round_shift(acc, 6));
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        m[i][c] = clamp32(rot[i][c]);
                    end
                    m[i][3] = clamp32(ofs[i] << 10);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    palette[bone][i][c] = m[i][c];
                end
                r.bone = 7'(bone);
                r.row  = 2'(i);
                r.c0   = 32'(m[i][0]);
                r.c1   = 32'(m[i][1]);
                r.c2   = 32'(m[i][2]);
                r.ct   = 32'(m[i][3]);
                r.last = (2'(i) == bmp_pkg::ROW_LAST);
                pending_rows.push_back(r);
            end
        endfunction

        function void check_row(mat_row_t got);
            mat_row_t exp_row;
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected row bone %0d row %0d", got.bone, got.row);
                end
                return;
            end
            exp_row = pending_rows.pop_front();
            if (got.bone !== exp_row.bone || got.row !== exp_row.row || got.c0 !== exp_row.c0
                || got.c1 !== exp_row.c1 || got.c2 !== exp_row.c2 || got.ct !== exp_row.ct
                || got.last !== exp_row.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: row mismatch exp b%0d r%0d %0d %0d %0d %0d l%0b",
                             exp_row.bone, exp_row.row, exp_row.c0, exp_row.c1, exp_row.c2,
                             exp_row.ct, exp_row.last);
                    $display("                     got b%0d r%0d %0d %0d %0d %0d l%0b",
                             got.bone, got.row, got.c0, got.c1, got.c2, got.ct, got.last);
                end
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    palette_scoreboard sb = new();

    // Which palette slots hold a matrix; a child only names a written parent.
    bit written_slot [128];
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int next_bone = 0;

    always #5 clk = ~clk;

    bone_matrix_palette_builder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // The receiver changes its stall pattern now and then: always ready, light
    // stalls, or heavy stalls, so that backpressure lands on every row step.
    always @(posedge clk)
    begin
        mat_row_t got;
        if (m_tvalid && m_tready)
        begin
            got.bone = m_tdata[6:0];
            got.c0   = m_tdata[38:7];
            got.c1   = m_tdata[70:39];
            got.c2   = m_tdata[102:71];
            got.ct   = m_tdata[134:103];
            got.row  = m_tuser;
            got.last = m_tlast;
            sb.check_row(got);
        end
        if ($urandom_range(0, 63) == 0)
        begin
            stall_mode = $urandom_range(0, 2);
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: a run of cycles with no item moving on either stream or the register
    // port that reaches the idle_cycles limit ends the run as a failure.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= 4000)
        begin
            $display("bone_matrix_palette_builder_tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Two-phase APB write of the animated-bone count; pready is always high.
    task automatic write_bone_limit(int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bmp_pkg::REG_ANIM_BONE_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.animated_bones = value & 8'hFF;
    endtask

    // Offer one bone and wait for it to be taken. Valid stays high inside a burst;
    // when a burst ends it drops and a gap follows before the next burst.
    task automatic send_bone(logic [127:0] d);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_bone(d);
        written_slot[d[6:0]] = 1'b1;
        burst_left--;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
        end
    endtask

    // Hold the sender until every predicted row has come out, then let the pipeline settle.
    task automatic drain_rows();
        if (s_tvalid)
        begin
            @(posedge clk);
            s_tvalid <= 1'b0;
        end
        burst_left = 0;
        while (sb.pending_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [127:0] pack_bone(int bone, int parent, logic [15:0] qx,
                                               logic [15:0] qy, logic [15:0] qz,
                                               logic [15:0] qw, logic [15:0] ox,
                                               logic [15:0] oy, logic [15:0] oz);
        logic [7:0] p;
        p = 8'(parent);
        return {1'b0, oz, oy, ox, qw, qz, qy, qx, p, bone[6:0]};
    endfunction

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Random bone: mostly the next bone of a skeleton walk, otherwise an arbitrary slot.
    // The parent is mostly an earlier written slot, otherwise negative or not earlier.
    function automatic logic [127:0] random_bone();
        int bone;
        int parent;
        if ($urandom_range(0, 4) != 0)
        begin
            bone = next_bone;
            next_bone = (next_bone + 1) % $urandom_range(8, 128);
        end
        else
        begin
            bone = $urandom_range(0, 127);
        end
        case ($urandom_range(0, 5))
            0: parent = -$urandom_range(1, 128);
            1: parent = $urandom_range(bone, 127);
            default: parent = (bone == 0) ? -1 : $urandom_range(0, bone - 1);
        endcase
        // A parent that names an empty earlier slot would read undefined memory.
        if (parent >= 0 && parent < bone && !written_slot[parent])
        begin
            parent = -1;
        end
        return pack_bone(bone, parent, pick_component(), pick_component(), pick_component(),
                         pick_component(), pick_component(), pick_component(),
                         pick_component());
    endfunction

    initial
    begin
        int counts [6];
        counts = '{128, 0, 1, 127, 64, 128};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, all bones animated: field extremes, every parent case,
        // an unnormalized quaternion, then more bones with no animation.
        write_bone_limit(128);
        send_bone(pack_bone(0, -1, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF,
                            16'h7FFF, 16'h8000, 16'h0001));
        send_bone(pack_bone(1, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000));
        send_bone(pack_bone(2, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_bone(pack_bone(3, 2, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                            16'h8000, 16'h7FFF, 16'h8000));
        send_bone(pack_bone(4, 3, 16'h5A82, 16'h0000, 16'h0000, 16'h5A82,
                            16'h0040, 16'hFFC0, 16'h0000));
        send_bone(pack_bone(5, 5, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                            16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_bone(pack_bone(6, 127, 16'h1234, 16'hEDCB, 16'h4000, 16'hC000,
                            16'h0100, 16'h0200, 16'hFF00));
        send_bone(pack_bone(7, -128, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000));
        send_bone(pack_bone(8, 4, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000,
                            16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_bone(pack_bone(127, 8, 16'h8000, 16'h0000, 16'h7FFF, 16'h0000,
                            16'h8000, 16'h8000, 16'h8000));
        send_bone(pack_bone(126, 127, 16'h2000, 16'h2000, 16'h2000, 16'h2000,
                            16'h0001, 16'h0002, 16'h0003));
        drain_rows();
        write_bone_limit(0);
        send_bone(pack_bone(9, 2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_bone(pack_bone(10, -1, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000));
        send_bone(pack_bone(127, 126, 16'h1111, 16'h2222, 16'h3333, 16'h4444,
                            16'h5555, 16'h6666, 16'h7777));
        drain_rows();

        // Random part in phases, each with its own animated-bone count.
        foreach (counts[i])
        begin
            write_bone_limit((i >= 4) ? $urandom_range(0, 128) : counts[i]);
            repeat (60) send_bone(random_bone());
            drain_rows();
        end

        if (sb.mismatches == 0 && sb.pending_rows.size() == 0)
        begin
            $display("bone_matrix_palette_builder_tb: PASS");
        end
        else
        begin
            $display("bone_matrix_palette_builder_tb: FAIL");
        end
        $finish;
    end

endmodule
